// ===== rtl/dmrs_pkg.sv =====
// ----------------------------------------------------------------------------
// dmrs_pkg
// Item types and register indexes shared by the dual motor ramp sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dmrs_pkg;

  // Input item: one command per item
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  left_req;
    logic [7:0]  right_req;
    logic        forward;
    logic        turn_cw;
    logic [31:0] hold_ticks;
  } in_item_t;

  // Result item: driver bytes in force plus status flags
  typedef struct packed {
    logic [7:0] left_control;
    logic [7:0] right_control;
    logic       write_strobe;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_DRIVE = 2'd1;
  localparam logic [1:0] CMD_TURN  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_EN     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_SPEED  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_TICKS  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_STEP  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_STEP   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_TICKS = 4'd7;

  // Speed and ramp constants
  localparam logic [5:0] SPEED_MAX = 6'h3F;
  localparam logic [5:0] RAMP_STEP = 6'h05;

  // Driver direction bits
  localparam logic [1:0] DIR_COAST = 2'b00;
  localparam logic [1:0] DIR_FWD   = 2'b01;
  localparam logic [1:0] DIR_REV   = 2'b10;
  localparam logic [1:0] DIR_BRAKE = 2'b11;

endpackage

`default_nettype wire

// ===== rtl/dual_motor_ramp_sequencer.sv =====
// Pipeline: an accepted item enters the input register, and its result goes
// into the result register (out_data) when that is free. Throughput: one item
// per cycle; the sequencer state updates in the cycle between the two registers,
// and a held result stalls the input only once both registers are full.
// Reset (rst_n low, synchronous): sequence idle, counters and ramp cleared,
// configuration back to its defaults, both register stages empty.
// ----------------------------------------------------------------------------
// dual_motor_ramp_sequencer
// Drive/turn command sequencer: gain-scaled targets, optional kick, stepped
// ramp, hold, brake, coast. Tick items advance time by one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_motor_ramp_sequencer #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input items
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  dmrs_pkg::in_item_t           in_data,
  // result items
  output logic                               out_valid,
  input  wire                                out_ready,
  output dmrs_pkg::out_item_t                out_data,
  // configuration writes
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [dmrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [15:0]                        cfg_data
);

  localparam int unsigned CB = COUNTER_BITS;
  localparam logic [31:0] CNT_MAX32 = 32'((64'd1 << CB) - 64'd1);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_KICK  = 3'd1;
  localparam logic [2:0] PH_RAMP  = 3'd2;
  localparam logic [2:0] PH_HOLD  = 3'd3;
  localparam logic [2:0] PH_BRAKE = 3'd4;

  // Configuration registers
  logic [7:0]  left_gain_r, right_gain_r;
  logic        kick_en_r;
  logic [5:0]  kick_lvl_r;
  logic [15:0] kick_ticks_r, drive_step_r, turn_step_r, brake_ticks_r;

  // Sequencer state
  logic [2:0]    phase_r, phase_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic [5:0]    level_r, level_nxt;
  logic [5:0]    lt_r, lt_nxt, rt_r, rt_nxt;
  logic          ldir_r, ldir_nxt, rdir_r, rdir_nxt;
  logic [CB-1:0] hold_r, hold_nxt;
  logic          turn_r, turn_nxt;

  // Pipeline registers
  logic                in_valid_r;
  dmrs_pkg::in_item_t  in_r;
  logic                out_valid_r;
  dmrs_pkg::out_item_t out_r, out_nxt;

  logic slot_free, proc_en;

  assign slot_free = !out_valid_r || out_ready;
  assign proc_en   = in_valid_r && slot_free;
  assign in_ready  = !in_valid_r || slot_free;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_gain_r   <= 8'd64;
      right_gain_r  <= 8'd64;
      kick_en_r     <= 1'b0;
      kick_lvl_r    <= 6'd0;
      kick_ticks_r  <= 16'd0;
      drive_step_r  <= 16'd100;
      turn_step_r   <= 16'd80;
      brake_ticks_r <= 16'd40;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dmrs_pkg::REG_LEFT_GAIN:   left_gain_r   <= cfg_data[7:0];
        dmrs_pkg::REG_RIGHT_GAIN:  right_gain_r  <= cfg_data[7:0];
        dmrs_pkg::REG_KICK_EN:     kick_en_r     <= cfg_data[0];
        dmrs_pkg::REG_KICK_SPEED:  kick_lvl_r    <= cfg_data[5:0];
        dmrs_pkg::REG_KICK_TICKS:  kick_ticks_r  <= cfg_data;
        dmrs_pkg::REG_DRIVE_STEP:  drive_step_r  <= cfg_data;
        dmrs_pkg::REG_TURN_STEP:   turn_step_r   <= cfg_data;
        dmrs_pkg::REG_BRAKE_TICKS: brake_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gain scaling: (speed * gain) >> 6, saturated to 6 bits
  logic [15:0] lprod, rprod;
  logic [5:0]  lscaled, rscaled;

  assign lprod   = 16'(in_r.left_req) * 16'(left_gain_r);
  assign rprod   = 16'(in_r.right_req) * 16'(right_gain_r);
  assign lscaled = (|lprod[15:12]) ? dmrs_pkg::SPEED_MAX : lprod[11:6];
  assign rscaled = (|rprod[15:12]) ? dmrs_pkg::SPEED_MAX : rprod[11:6];

  // Hold length clamped to the counter range
  logic [CB-1:0] hold_sat;
  assign hold_sat = (in_r.hold_ticks > CNT_MAX32) ? CNT_MAX32[CB-1:0]
                                                  : in_r.hold_ticks[CB-1:0];

  // Next state and result
  logic          busy, strobe, rej;
  logic          enter_ramp, enter_hold, enter_brake, enter_coast;
  logic          ramp_tick;
  logic [5:0]    maxt;
  logic [15:0]   step_raw;
  logic [CB-1:0] step_len;
  logic          ramp_more;
  logic [5:0]    lspd, rspd;

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    level_nxt   = level_r;
    lt_nxt      = lt_r;
    rt_nxt      = rt_r;
    ldir_nxt    = ldir_r;
    rdir_nxt    = rdir_r;
    hold_nxt    = hold_r;
    turn_nxt    = turn_r;
    strobe      = 1'b0;
    rej         = 1'b0;
    enter_ramp  = 1'b0;
    enter_hold  = 1'b0;
    enter_brake = 1'b0;
    enter_coast = 1'b0;
    ramp_tick   = 1'b0;
    busy        = (phase_r != PH_IDLE);

    // command decode
    unique case (in_r.command)
      dmrs_pkg::CMD_DRIVE, dmrs_pkg::CMD_TURN: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          lt_nxt    = lscaled;
          rt_nxt    = rscaled;
          hold_nxt  = hold_sat;
          level_nxt = 6'd0;
          strobe    = 1'b1;
          if (in_r.command == dmrs_pkg::CMD_DRIVE) begin
            turn_nxt = 1'b0;
            ldir_nxt = in_r.forward;
            rdir_nxt = in_r.forward;
          end else begin
            turn_nxt = 1'b1;
            ldir_nxt = in_r.turn_cw;
            rdir_nxt = !in_r.turn_cw;
          end
          if (kick_en_r && (kick_ticks_r != 16'd0)) begin
            phase_nxt = PH_KICK;
            cnt_nxt   = CB'(kick_ticks_r);
          end else begin
            enter_ramp = 1'b1;
          end
        end
      end
      dmrs_pkg::CMD_TICK: begin
        if (busy) begin
          if (cnt_r > CB'(1)) begin
            cnt_nxt = cnt_r - CB'(1);
          end else begin
            cnt_nxt = '0;
            strobe  = 1'b1;
            unique case (phase_r)
              PH_KICK:  enter_ramp  = 1'b1;
              PH_RAMP:  ramp_tick   = 1'b1;
              PH_HOLD:  enter_brake = 1'b1;
              default:  enter_coast = 1'b1;
            endcase
          end
        end
      end
      default: ;
    endcase

    // ramp interval and step test from the targets and mode now in force
    maxt     = (lt_nxt > rt_nxt) ? lt_nxt : rt_nxt;
    step_raw = turn_nxt ? turn_step_r : drive_step_r;
    step_len = (step_raw == 16'd0) ? CB'(1) : CB'(step_raw);
    ramp_more = (level_r > maxt) || ((maxt - level_r) >= dmrs_pkg::RAMP_STEP);

    // end of a ramp interval: one more step, or on to the hold
    if (ramp_tick) begin
      if (ramp_more) begin
        level_nxt = level_r + dmrs_pkg::RAMP_STEP;
        cnt_nxt   = step_len;
      end else begin
        enter_hold = 1'b1;
      end
    end

    // phase entry chain; zero-length phases fall through
    if (enter_ramp) begin
      if (maxt >= dmrs_pkg::RAMP_STEP) begin
        phase_nxt = PH_RAMP;
        level_nxt = dmrs_pkg::RAMP_STEP;
        cnt_nxt   = step_len;
      end else begin
        enter_hold = 1'b1;
      end
    end
    if (enter_hold) begin
      if (hold_nxt != '0) begin
        phase_nxt = PH_HOLD;
        cnt_nxt   = hold_nxt;
      end else begin
        enter_brake = 1'b1;
      end
    end
    if (enter_brake) begin
      if (brake_ticks_r != 16'd0) begin
        phase_nxt = PH_BRAKE;
        cnt_nxt   = CB'(brake_ticks_r);
      end else begin
        enter_coast = 1'b1;
      end
    end
    if (enter_coast) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
      level_nxt = 6'd0;
    end

    // driver bytes for the phase now in force
    lspd = (level_nxt <= lt_nxt) ? level_nxt : lt_nxt;
    rspd = (level_nxt <= rt_nxt) ? level_nxt : rt_nxt;
    unique case (phase_nxt)
      PH_KICK: begin
        out_nxt.left_control  = {kick_lvl_r,
                                 ldir_nxt ? dmrs_pkg::DIR_FWD : dmrs_pkg::DIR_REV};
        out_nxt.right_control = {kick_lvl_r,
                                 rdir_nxt ? dmrs_pkg::DIR_FWD : dmrs_pkg::DIR_REV};
      end
      PH_RAMP: begin
        out_nxt.left_control  = {lspd,
                                 ldir_nxt ? dmrs_pkg::DIR_FWD : dmrs_pkg::DIR_REV};
        out_nxt.right_control = {rspd,
                                 rdir_nxt ? dmrs_pkg::DIR_FWD : dmrs_pkg::DIR_REV};
      end
      PH_HOLD: begin
        out_nxt.left_control  = {lt_nxt,
                                 ldir_nxt ? dmrs_pkg::DIR_FWD : dmrs_pkg::DIR_REV};
        out_nxt.right_control = {rt_nxt,
                                 rdir_nxt ? dmrs_pkg::DIR_FWD : dmrs_pkg::DIR_REV};
      end
      PH_BRAKE: begin
        out_nxt.left_control  = {6'd0, dmrs_pkg::DIR_BRAKE};
        out_nxt.right_control = {6'd0, dmrs_pkg::DIR_BRAKE};
      end
      default: begin
        out_nxt.left_control  = {6'd0, dmrs_pkg::DIR_COAST};
        out_nxt.right_control = {6'd0, dmrs_pkg::DIR_COAST};
      end
    endcase
    out_nxt.write_strobe = strobe;
    out_nxt.busy_res     = (phase_nxt != PH_IDLE);
    out_nxt.rejected     = rej;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Sequencer state update, one item per cycle while the result slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      level_r <= 6'd0;
      lt_r    <= 6'd0;
      rt_r    <= 6'd0;
      ldir_r  <= 1'b0;
      rdir_r  <= 1'b0;
      hold_r  <= '0;
      turn_r  <= 1'b0;
    end else if (proc_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      level_r <= level_nxt;
      lt_r    <= lt_nxt;
      rt_r    <= rt_nxt;
      ldir_r  <= ldir_nxt;
      rdir_r  <= rdir_nxt;
      hold_r  <= hold_nxt;
      turn_r  <= turn_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_dual_motor_ramp_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_dual_motor_ramp_sequencer
// Self-checking bench for the dual motor ramp sequencer. Drive, turn, tick
// and unused items go in with random gaps. A scoreboard tracks kick, ramp,
// hold, brake and coast from each accepted item and checks every result item
// field by field. The run covers several register settings, the extremes
// among them, and it stalls the result side for a long stretch.
// ----------------------------------------------------------------------------
module tb_dual_motor_ramp_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code with no function; the block ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Register index outside the map; a write to it changes nothing
  localparam logic [dmrs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

  localparam int RANDOM_ITEMS    = 700;
  localparam int PHASE_ITEMS     = 140;
  localparam int IDLE_PCT        = 19;
  localparam int HOLD_OFF_CYCLES = 64;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_KICK, SEQ_RAMP, SEQ_HOLD, SEQ_BRAKE
  } seq_phase_t;

  // --------------------------------------------------------------------------
  // Scoreboard: follows the motor sequence and holds the result items due
  // --------------------------------------------------------------------------
  class ramp_scoreboard;
    // register copies
    logic [7:0]  left_gain, right_gain;
    logic        kick_en;
    logic [5:0]  kick_lvl;
    logic [15:0] kick_len, drive_step, turn_step, brake_len;
    // sequence state
    seq_phase_t  phase;
    logic [31:0] countdown, hold_len;
    logic [5:0]  level, tgt_l, tgt_r;
    logic        dir_l, dir_r, turning;
    dmrs_pkg::out_item_t expected_bytes_q[$];
    int          errors;

    function new();
      left_gain  = 8'd64;
      right_gain = 8'd64;
      kick_en    = 1'b0;
      kick_lvl   = '0;
      kick_len   = '0;
      drive_step = 16'd100;
      turn_step  = 16'd80;
      brake_len  = 16'd40;
      phase      = SEQ_IDLE;
      countdown  = '0;
      hold_len   = '0;
      level      = '0;
      tgt_l      = '0;
      tgt_r      = '0;
      dir_l      = 1'b0;
      dir_r      = 1'b0;
      turning    = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [dmrs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        dmrs_pkg::REG_LEFT_GAIN:   left_gain  = val[7:0];
        dmrs_pkg::REG_RIGHT_GAIN:  right_gain = val[7:0];
        dmrs_pkg::REG_KICK_EN:     kick_en    = val[0];
        dmrs_pkg::REG_KICK_SPEED:  kick_lvl   = val[5:0];
        dmrs_pkg::REG_KICK_TICKS:  kick_len   = val;
        dmrs_pkg::REG_DRIVE_STEP:  drive_step = val;
        dmrs_pkg::REG_TURN_STEP:   turn_step  = val;
        dmrs_pkg::REG_BRAKE_TICKS: brake_len  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_bytes_q.size();
    endfunction

    function bit busy();
      return phase != SEQ_IDLE;
    endfunction

    // speed * gain with 6 fraction bits, clipped to the 6-bit speed code
    function logic [5:0] scaled(logic [7:0] spd, logic [7:0] gain);
      logic [15:0] prod;
      prod = (16'(spd) * 16'(gain)) >> 6;
      return (prod > 16'(dmrs_pkg::SPEED_MAX)) ? dmrs_pkg::SPEED_MAX : prod[5:0];
    endfunction

    // a zero interval behaves as one tick
    function logic [31:0] step_len();
      logic [15:0] s;
      s = turning ? turn_step : drive_step;
      return (s == '0) ? 32'd1 : 32'(s);
    endfunction

    function logic [5:0] max_tgt();
      return (tgt_l > tgt_r) ? tgt_l : tgt_r;
    endfunction

    function logic [7:0] drive_byte(logic [5:0] spd, logic dir);
      return {spd, dir ? dmrs_pkg::DIR_FWD : dmrs_pkg::DIR_REV};
    endfunction

    // phase entries; zero-length phases fall through to the next one
    function void enter_coast();
      phase     = SEQ_IDLE;
      countdown = '0;
      level     = '0;
    endfunction

    function void enter_brake();
      if (brake_len == '0) begin
        enter_coast();
      end else begin
        phase     = SEQ_BRAKE;
        countdown = 32'(brake_len);
      end
    endfunction

    function void enter_hold();
      if (hold_len == '0) begin
        enter_brake();
      end else begin
        phase     = SEQ_HOLD;
        countdown = hold_len;
      end
    endfunction

    function void enter_ramp();
      if (max_tgt() >= dmrs_pkg::RAMP_STEP) begin
        phase     = SEQ_RAMP;
        level     = dmrs_pkg::RAMP_STEP;
        countdown = step_len();
      end else begin
        enter_hold();
      end
    endfunction

    // one accepted input item -> one expected result item
    function void note_command(dmrs_pkg::in_item_t it);
      dmrs_pkg::out_item_t exp_r;
      logic [5:0] l, r;
      logic       was_busy;
      was_busy = (phase != SEQ_IDLE);
      exp_r    = '0;
      if (it.command == dmrs_pkg::CMD_DRIVE || it.command == dmrs_pkg::CMD_TURN) begin
        if (was_busy) begin
          exp_r.rejected = 1'b1;
        end else begin
          tgt_l = scaled(it.left_req, left_gain);
          tgt_r = scaled(it.right_req, right_gain);
          if (it.command == dmrs_pkg::CMD_DRIVE) begin
            turning = 1'b0;
            dir_l   = it.forward;
            dir_r   = it.forward;
          end else begin
            turning = 1'b1;
            dir_l   = it.turn_cw;
            dir_r   = ~it.turn_cw;
          end
          // countdown is the full 32 bits, so any hold fits without clipping
          hold_len = it.hold_ticks;
          level    = '0;
          if (kick_en && kick_len != '0) begin
            phase     = SEQ_KICK;
            countdown = 32'(kick_len);
          end else begin
            enter_ramp();
          end
          exp_r.write_strobe = 1'b1;
        end
      end else if (it.command == dmrs_pkg::CMD_TICK && was_busy) begin
        if (countdown > 32'd1) begin
          countdown--;
        end else begin
          countdown          = '0;
          exp_r.write_strobe = 1'b1;
          case (phase)
            SEQ_KICK: enter_ramp();
            SEQ_RAMP: begin
              if (int'(max_tgt()) - int'(level) >= int'(dmrs_pkg::RAMP_STEP)) begin
                level     = level + dmrs_pkg::RAMP_STEP;
                countdown = step_len();
              end else begin
                enter_hold();
              end
            end
            SEQ_HOLD: enter_brake();
            default:  enter_coast();
          endcase
        end
      end

      // driver bytes in force after this item
      case (phase)
        SEQ_KICK: begin
          exp_r.left_control  = drive_byte(kick_lvl, dir_l);
          exp_r.right_control = drive_byte(kick_lvl, dir_r);
        end
        SEQ_RAMP: begin
          l = (level <= tgt_l) ? level : tgt_l;
          r = (level <= tgt_r) ? level : tgt_r;
          exp_r.left_control  = drive_byte(l, dir_l);
          exp_r.right_control = drive_byte(r, dir_r);
        end
        SEQ_HOLD: begin
          exp_r.left_control  = drive_byte(tgt_l, dir_l);
          exp_r.right_control = drive_byte(tgt_r, dir_r);
        end
        SEQ_BRAKE: begin
          exp_r.left_control  = {6'd0, dmrs_pkg::DIR_BRAKE};
          exp_r.right_control = {6'd0, dmrs_pkg::DIR_BRAKE};
        end
        default: ;
      endcase
      exp_r.busy_res = (phase != SEQ_IDLE);
      expected_bytes_q.push_back(exp_r);
    endfunction

    function void cmp_field(string fld, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s expected 0x%02h, got 0x%02h", $time, fld, exp_v, act_v);
      end
    endfunction

    function void check_result(dmrs_pkg::out_item_t got);
      dmrs_pkg::out_item_t exp_r;
      if (expected_bytes_q.size() == 0) begin
        errors++;
        $display("%0t: result expected none, got 0x%h", $time, got);
        return;
      end
      exp_r = expected_bytes_q.pop_front();
      cmp_field("left_control", exp_r.left_control, got.left_control);
      cmp_field("right_control", exp_r.right_control, got.right_control);
      cmp_field("write_strobe", 8'(exp_r.write_strobe), 8'(got.write_strobe));
      cmp_field("busy_res", 8'(exp_r.busy_res), 8'(got.busy_res));
      cmp_field("rejected", 8'(exp_r.rejected), 8'(got.rejected));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  dmrs_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  dmrs_pkg::out_item_t            out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [dmrs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                    cfg_data;

  bit steady;        // no idling on either side while set
  bit hold_off_req;  // receiver holds off for a long stretch
  int items_sent;

  ramp_scoreboard sb = new();

  dual_motor_ramp_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL dual_motor_ramp_sequencer");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready = steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  function automatic dmrs_pkg::in_item_t make_item(logic [1:0] cmd, logic [7:0] ls,
                                                   logic [7:0] rs, logic fwd, logic tr,
                                                   logic [31:0] hold);
    dmrs_pkg::in_item_t it;
    it.command    = cmd;
    it.left_req   = ls;
    it.right_req  = rs;
    it.forward    = fwd;
    it.turn_cw    = tr;
    it.hold_ticks = hold;
    return it;
  endfunction

  // well-formed start: short holds, some speeds low enough to skip the ramp
  function automatic dmrs_pkg::in_item_t rand_start();
    logic [1:0]  cmd;
    logic [7:0]  ls, rs;
    logic [31:0] hold;
    cmd  = $urandom_range(1) ? dmrs_pkg::CMD_TURN : dmrs_pkg::CMD_DRIVE;
    ls   = ($urandom_range(3) == 0) ? 8'($urandom_range(12)) : 8'($urandom);
    rs   = ($urandom_range(3) == 0) ? 8'($urandom_range(12)) : 8'($urandom);
    hold = ($urandom_range(9) == 0) ? 32'($urandom_range(40)) : 32'($urandom_range(6));
    return make_item(cmd, ls, rs, 1'($urandom_range(1)), 1'($urandom_range(1)), hold);
  endfunction

  // tick with junk in the unused fields
  function automatic dmrs_pkg::in_item_t tick_item();
    return make_item(dmrs_pkg::CMD_TICK, 8'($urandom), 8'($urandom),
                     1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
  endfunction

  // start (only sent while busy, so rejected) or unused code, all fields random
  function automatic dmrs_pkg::in_item_t noise_item();
    logic [1:0] cmd;
    case ($urandom_range(2))
      0:       cmd = dmrs_pkg::CMD_DRIVE;
      1:       cmd = dmrs_pkg::CMD_TURN;
      default: cmd = CMD_UNUSED;
    endcase
    return make_item(cmd, 8'($urandom), 8'($urandom), 1'($urandom_range(1)),
                     1'($urandom_range(1)), $urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // offer one item; returns at the accepting edge with valid still high
  task automatic send_item(dmrs_pkg::in_item_t item);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    sb.note_command(item);
    items_sent++;
  endtask

  // stop offering and wait until every result has come, plus the pipeline depth
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [dmrs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_config(logic [7:0] lg, logic [7:0] rg, logic ken,
                              logic [5:0] ks, logic [15:0] kt, logic [15:0] ds,
                              logic [15:0] ts, logic [15:0] bt);
    wait_drained();
    write_reg(dmrs_pkg::REG_LEFT_GAIN, 16'(lg));
    write_reg(dmrs_pkg::REG_RIGHT_GAIN, 16'(rg));
    write_reg(dmrs_pkg::REG_KICK_EN, 16'(ken));
    write_reg(dmrs_pkg::REG_KICK_SPEED, 16'(ks));
    write_reg(dmrs_pkg::REG_KICK_TICKS, kt);
    write_reg(dmrs_pkg::REG_DRIVE_STEP, ds);
    write_reg(dmrs_pkg::REG_TURN_STEP, ts);
    write_reg(dmrs_pkg::REG_BRAKE_TICKS, bt);
  endtask

  // tick the running sequence out, with some rejected starts and unused codes
  task automatic finish_sequence(int noise_pct);
    while (sb.busy()) begin
      if ($urandom_range(99) < noise_pct) begin
        send_item(noise_item());
      end else begin
        send_item(tick_item());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int   first_item;
    int   phase_start;
    int   phase_no;
    bit   hold_off_done;
    bit   pause_done;
    logic ken;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    items_sent   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: idle tick, unused code, short ramp skipped, one-tick hold,
    // default brake; a start and an unused code while busy
    send_item(make_item(dmrs_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0));
    send_item(make_item(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(dmrs_pkg::CMD_DRIVE, 8'd4, 8'd4, 1'b1, 1'b0, 32'd1));
    send_item(make_item(dmrs_pkg::CMD_TURN, 8'hFF, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(CMD_UNUSED, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0));
    finish_sequence(0);

    // zero-length kick and brake
    apply_config(8'd64, 8'd64, 1'b1, 6'd63, 16'd0, 16'd1, 16'd2, 16'd0);
    send_item(make_item(dmrs_pkg::CMD_DRIVE, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    send_item(make_item(dmrs_pkg::CMD_TURN, 8'hFF, 8'hFF, 1'b0, 1'b1, 32'd2));
    finish_sequence(0);
    // right target below one step: only the left motor ramps
    send_item(make_item(dmrs_pkg::CMD_TURN, 8'd20, 8'd3, 1'b1, 1'b0, 32'd1));
    finish_sequence(0);
    send_item(make_item(dmrs_pkg::CMD_DRIVE, 8'hFF, 8'd0, 1'b1, 1'b1, 32'd0));
    send_item(make_item(dmrs_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0));

    // low extremes: zero gains, kick on with zero length, zero intervals
    apply_config(8'd0, 8'd0, 1'b1, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    repeat (3) begin
      send_item(rand_start());
      finish_sequence(10);
    end

    // full gains, one-tick kick at top speed, zero step intervals
    apply_config(8'd255, 8'd255, 1'b1, 6'd63, 16'd1, 16'd0, 16'd0, 16'd1);
    repeat (4) begin
      send_item(rand_start());
      finish_sequence(10);
    end

    // high extremes loaded; kick off and low speeds keep the long phases out
    apply_config(8'd255, 8'd255, 1'b0, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3);
    send_item(make_item(dmrs_pkg::CMD_DRIVE, 8'd1, 8'd1, 1'b0, 1'b0, 32'd0));
    finish_sequence(2);

    // random settings, mostly whole sequences with noise in between
    first_item    = items_sent;
    phase_no      = 0;
    hold_off_done = 1'b0;
    pause_done    = 1'b0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      ken = 1'($urandom_range(1));
      apply_config(8'($urandom), 8'($urandom), ken, 6'($urandom),
                   ken ? 16'($urandom_range(4)) : 16'($urandom),
                   16'($urandom_range(3)), 16'($urandom_range(3)),
                   16'($urandom_range(4)));
      steady      = (phase_no == 1);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS &&
             items_sent - first_item < RANDOM_ITEMS) begin
        if (phase_no == 0 && !hold_off_done && items_sent - phase_start > 20) begin
          hold_off_req  = 1'b1;
          hold_off_done = 1'b1;
        end
        if (phase_no == 2 && !pause_done && items_sent - phase_start > 40) begin
          wait_drained();
          pause_done = 1'b1;
        end
        if ($urandom_range(4) == 0) begin
          send_item($urandom_range(1) ? tick_item()
                                      : make_item(CMD_UNUSED, 8'($urandom), 8'($urandom),
                                                  1'($urandom_range(1)),
                                                  1'($urandom_range(1)), $urandom));
        end
        send_item(rand_start());
        finish_sequence(8);
      end
      phase_no++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS dual_motor_ramp_sequencer");
    end else begin
      $display("FAIL dual_motor_ramp_sequencer");
    end
    $finish;
  end

endmodule
